/* rtl/bact_pkg.sv */
// Package for the bump arena commit tracker: widths, codes, item types and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bact_pkg;

    localparam int OFF_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int DIV_CNT_W = $clog2(OFF_W);

    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMIT_GRAN   = 1'b1;

    localparam logic [OFF_W-1:0] RESERVED_RST = OFF_W'(268435456);
    localparam logic [OFF_W-1:0] GRAN_RST     = OFF_W'(4096);

    localparam logic [2:0] ACT_PUSH    = 3'd0;
    localparam logic [2:0] ACT_ALIGNED = 3'd1;
    localparam logic [2:0] ACT_RESERVE = 3'd2;
    localparam logic [2:0] ACT_GROWTH  = 3'd3;
    localparam logic [2:0] ACT_RESET   = 3'd4;
    localparam logic [2:0] ACT_QUERY   = 3'd5;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_SIZE  = 2'd1,
        ST_NO_MEM    = 2'd2,
        ST_BAD_PARAM = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]       action;
        logic [OFF_W-1:0] size;
        logic [OFF_W-1:0] alignment;
        logic [OFF_W-1:0] capacity_target;
        logic [OFF_W-1:0] expected_total;
    } t_in_item;

    typedef struct packed {
        t_status          status;
        logic [OFF_W-1:0] block_offset;
        logic [OFF_W-1:0] allocated_now;
        logic [OFF_W-1:0] committed_now;
        logic [OFF_W-1:0] headroom;
        logic             fits;
    } t_out_item;

    // Source of the bump operand.
    typedef enum logic [1:0] {
        OP_SIZE    = 2'd0,
        OP_ONE     = 2'd1,
        OP_PAD     = 2'd2,
        OP_SIZE_M1 = 2'd3
    } t_op_sel;

    // Source of the watermark target.
    typedef enum logic [1:0] {
        TGT_CAP    = 2'd0,
        TGT_GROWTH = 2'd1,
        TGT_END    = 2'd2
    } t_tgt_sel;

    typedef struct packed {
        logic     capture;
        logic     op_ld;
        t_op_sel  op_sel;
        logic     align_ld;
        logic     tgt_ld;
        t_tgt_sel tgt_sel;
        logic     bump_commit;
        logic     where_alloc;
        logic     clr_alloc;
        logic     div_start;
        logic     grow_commit;
        logic     finish;
        t_status  fin_status;
    } t_cmd;

    typedef struct packed {
        logic [2:0] action;
        logic       in_valid;
        logic       op_zero;
        logic       end_over;
        logic       end_above;
        logic       tgt_over;
        logic       tgt_covered;
        logic       align_bad;
        logic       pad_gt1;
        logic       size_gt1;
        logic       div_done;
        logic       out_free;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/bact_ifs.sv */
// Valid/ready channel interfaces for input and result items.
// Depends on bact_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface bact_in_if;
    logic               valid;
    logic               ready;
    bact_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bact_out_if;
    logic                valid;
    logic                ready;
    bact_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/bact_div.sv */
// Radix-2 restoring remainder unit, one quotient bit per cycle.
// Depends on bact_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module bact_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [bact_pkg::OFF_W-1:0] i_dividend,
    input  wire logic [bact_pkg::OFF_W-1:0] i_divisor,
    output logic                            o_done,
    output logic [bact_pkg::OFF_W-1:0]      o_rem
);

    localparam logic [bact_pkg::DIV_CNT_W-1:0] CNT_LAST =
        bact_pkg::DIV_CNT_W'(bact_pkg::OFF_W - 1);

    logic                            r_busy;
    logic                            r_done;
    logic [bact_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [bact_pkg::OFF_W-1:0]      r_dvd;
    logic [bact_pkg::OFF_W-1:0]      r_dvs;
    logic [bact_pkg::OFF_W-1:0]      r_rem;

    logic [bact_pkg::OFF_W:0]        w_trial;
    logic [bact_pkg::OFF_W:0]        w_diff;
    logic [bact_pkg::OFF_W-1:0]      n_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[bact_pkg::OFF_W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        if (w_trial >= {1'b0, r_dvs}) begin
            n_rem = w_diff[bact_pkg::OFF_W-1:0];
        end else begin
            n_rem = w_trial[bact_pkg::OFF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[bact_pkg::OFF_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

/* rtl/bact_datapath.sv */
// Datapath: configuration, allocated offset, committed watermark, operand and
// target registers, the remainder unit and the result register. Uses bact_pkg, bact_div.
`timescale 1ns / 1ps
`default_nettype none

module bact_datapath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [bact_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bact_pkg::OFF_W-1:0]     i_cfg_data,
    input  wire logic                           i_in_valid,
    input  bact_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output bact_pkg::t_out_item                 o_out_data,
    input  bact_pkg::t_cmd                      i_cmd,
    output bact_pkg::t_sts                      o_sts
);

    localparam int W = bact_pkg::OFF_W;

    logic [W-1:0]        r_res_size;
    logic [W-1:0]        r_gran;
    logic [W-1:0]        r_alloc;
    logic [W-1:0]        r_comm;
    logic                r_out_valid;
    bact_pkg::t_in_item  r_in;
    logic [W-1:0]        r_am1;
    logic [W-1:0]        r_cur;
    logic [W:0]          r_where;
    logic [W-1:0]        r_op;
    logic [W:0]          r_target;
    logic [W-1:0]        r_pad;
    bact_pkg::t_out_item r_out;

    logic [W-1:0]        w_gran_eff;
    logic [W-3:0]        w_rnd_hi;
    logic [W:0]          w_rnd;
    logic [W+1:0]        w_end;
    logic [W:0]          w_aligned;
    logic [W:0]          w_pad_m1;
    logic [W-1:0]        w_size_m1;
    logic [W:0]          w_dbl;
    logic [W:0]          w_quarter;
    logic [W:0]          w_grow_tgt;
    logic [W-1:0]        w_needed;
    logic [W:0]          w_next;
    logic [W-1:0]        w_grown;
    logic [W:0]          w_hdiff;
    logic [W-1:0]        w_head;
    logic                w_fits;
    logic                w_div_done;
    logic [W-1:0]        w_rem;

    always_comb begin
        w_gran_eff = (r_gran == '0) ? W'(1) : r_gran;
        // Round the operand up to a multiple of eight.
        w_rnd_hi   = {1'b0, r_op[W-1:3]} + (W-2)'(|r_op[2:0]);
        w_rnd      = {w_rnd_hi, 3'b000};
        w_end      = {2'b00, r_alloc} + {1'b0, w_rnd};
        w_aligned  = ({1'b0, r_alloc} + {1'b0, r_am1}) & ~{1'b0, r_am1};
        // Padding minus one, as one add: where + ~cur.
        w_pad_m1   = r_where + ~{1'b0, r_cur};
        w_size_m1  = r_in.size - W'(1);
        w_dbl      = {r_in.size, 1'b0};
        w_quarter  = {3'b000, r_in.expected_total[W-1:2]};
        w_grow_tgt = (w_dbl < w_quarter) ? w_quarter : w_dbl;
        w_needed   = r_target[W-1:0] - r_comm;
        w_next     = r_target + {1'b0, r_pad};
        w_grown    = (w_next > {1'b0, r_res_size}) ? r_res_size : w_next[W-1:0];
        w_hdiff    = {1'b0, r_res_size} - {1'b0, r_alloc};
        w_head     = w_hdiff[W] ? '0 : w_hdiff[W-1:0];
        w_fits     = ({1'b0, r_alloc} + {1'b0, r_in.size}) <= {1'b0, r_res_size};
    end

    bact_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_needed),
        .i_divisor  (w_gran_eff),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_size  <= bact_pkg::RESERVED_RST;
            r_gran      <= bact_pkg::GRAN_RST;
            r_alloc     <= '0;
            r_comm      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bact_pkg::CFG_RESERVED_SIZE: r_res_size <= i_cfg_data;
                    bact_pkg::CFG_COMMIT_GRAN:   r_gran     <= i_cfg_data;
                endcase
            end
            if (i_cmd.clr_alloc) begin
                r_alloc <= '0;
            end else if (i_cmd.bump_commit) begin
                r_alloc <= w_end[W-1:0];
            end
            if (i_cmd.grow_commit) begin
                r_comm <= w_grown;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in    <= i_in_data;
            r_am1   <= i_in_data.alignment - W'(1);
            r_where <= '0;
        end
        if (i_cmd.align_ld) begin
            r_cur   <= r_alloc;
            r_where <= w_aligned;
        end
        if (i_cmd.bump_commit && i_cmd.where_alloc) begin
            r_where <= {1'b0, r_alloc};
        end
        if (i_cmd.op_ld) begin
            unique case (i_cmd.op_sel)
                bact_pkg::OP_SIZE:    r_op <= r_in.size;
                bact_pkg::OP_ONE:     r_op <= W'(1);
                bact_pkg::OP_PAD:     r_op <= w_pad_m1[W-1:0];
                bact_pkg::OP_SIZE_M1: r_op <= w_size_m1;
            endcase
        end
        if (i_cmd.tgt_ld) begin
            case (i_cmd.tgt_sel)
                bact_pkg::TGT_CAP:    r_target <= {1'b0, r_in.capacity_target};
                bact_pkg::TGT_GROWTH: r_target <= w_grow_tgt;
                default:              r_target <= w_end[W:0];
            endcase
        end
        if (w_div_done) begin
            r_pad <= (w_rem == '0) ? '0 : (w_gran_eff - w_rem);
        end
        if (i_cmd.finish) begin
            r_out.status        <= i_cmd.fin_status;
            r_out.block_offset  <= (i_cmd.fin_status == bact_pkg::ST_OK) ?
                                   r_where[W-1:0] : '0;
            r_out.allocated_now <= r_alloc;
            r_out.committed_now <= r_comm;
            r_out.headroom      <= w_head;
            r_out.fits          <= w_fits;
        end
    end

    always_comb begin
        o_sts.action      = r_in.action;
        o_sts.in_valid    = i_in_valid;
        o_sts.op_zero     = (r_op == '0);
        o_sts.end_over    = (w_end > {2'b00, r_res_size});
        o_sts.end_above   = (w_end > {2'b00, r_comm});
        o_sts.tgt_over    = (r_target > {1'b0, r_res_size});
        o_sts.tgt_covered = ({1'b0, r_comm} >= r_target);
        o_sts.align_bad   = (r_in.alignment == '0) || ((r_in.alignment & r_am1) != '0);
        o_sts.pad_gt1     = (w_pad_m1 != '0) && (w_pad_m1 != '1);
        o_sts.size_gt1    = (r_in.size > W'(1));
        o_sts.div_done    = w_div_done;
        o_sts.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* rtl/bact_ctrl.sv */
// Controller state machine: sequences decode, sub-pushes, watermark growth and
// result hand-off. Uses bact_pkg for command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module bact_ctrl (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  bact_pkg::t_sts i_sts,
    output bact_pkg::t_cmd o_cmd,
    output logic          o_in_ready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_BUMP,
        S_RESERVE,
        S_GROW_START,
        S_DIV,
        S_GROW,
        S_NEXT,
        S_FINISH
    } t_state;

    // Sub-push of an aligned push: one byte, padding, body.
    typedef enum logic [1:0] {
        PH_ONE_BYTE,
        PH_PADDING,
        PH_BODY
    } t_phase;

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    bact_pkg::t_status r_fin, n_fin;
    logic              r_in_ready, n_in_ready;

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_fin      = r_fin;
        n_in_ready = r_in_ready;
        o_cmd      = '0;
        o_cmd.fin_status = r_fin;

        unique case (r_state)
            S_IDLE: begin
                if (r_in_ready && i_sts.in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_in_ready    = 1'b0;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_phase = PH_ONE_BYTE;
                unique case (i_sts.action)
                    bact_pkg::ACT_PUSH: begin
                        o_cmd.op_ld  = 1'b1;
                        o_cmd.op_sel = bact_pkg::OP_SIZE;
                        n_state      = S_BUMP;
                    end
                    bact_pkg::ACT_ALIGNED: begin
                        if (i_sts.align_bad) begin
                            n_fin   = bact_pkg::ST_BAD_PARAM;
                            n_state = S_FINISH;
                        end else begin
                            o_cmd.align_ld = 1'b1;
                            o_cmd.op_ld    = 1'b1;
                            o_cmd.op_sel   = bact_pkg::OP_ONE;
                            n_state        = S_BUMP;
                        end
                    end
                    bact_pkg::ACT_RESERVE: begin
                        o_cmd.tgt_ld  = 1'b1;
                        o_cmd.tgt_sel = bact_pkg::TGT_CAP;
                        n_state       = S_RESERVE;
                    end
                    bact_pkg::ACT_GROWTH: begin
                        o_cmd.tgt_ld  = 1'b1;
                        o_cmd.tgt_sel = bact_pkg::TGT_GROWTH;
                        n_state       = S_RESERVE;
                    end
                    bact_pkg::ACT_RESET: begin
                        o_cmd.clr_alloc = 1'b1;
                        n_fin           = bact_pkg::ST_OK;
                        n_state         = S_FINISH;
                    end
                    bact_pkg::ACT_QUERY: begin
                        n_fin   = bact_pkg::ST_OK;
                        n_state = S_FINISH;
                    end
                    default: begin
                        n_fin   = bact_pkg::ST_BAD_PARAM;
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_BUMP: begin
                priority if (i_sts.op_zero) begin
                    n_fin   = bact_pkg::ST_BAD_SIZE;
                    n_state = S_FINISH;
                end else if (i_sts.end_over) begin
                    n_fin   = bact_pkg::ST_NO_MEM;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.bump_commit = 1'b1;
                    o_cmd.where_alloc = (i_sts.action == bact_pkg::ACT_PUSH);
                    o_cmd.tgt_ld      = 1'b1;
                    o_cmd.tgt_sel     = bact_pkg::TGT_END;
                    n_state           = i_sts.end_above ? S_GROW_START : S_NEXT;
                end
            end
            S_RESERVE: begin
                priority if (i_sts.tgt_over) begin
                    n_fin   = bact_pkg::ST_BAD_PARAM;
                    n_state = S_FINISH;
                end else if (i_sts.tgt_covered) begin
                    n_fin   = bact_pkg::ST_OK;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_GROW_START;
                end
            end
            S_GROW_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_GROW;
                end
            end
            S_GROW: begin
                o_cmd.grow_commit = 1'b1;
                n_state           = S_NEXT;
            end
            S_NEXT: begin
                n_fin   = bact_pkg::ST_OK;
                n_state = S_FINISH;
                if (i_sts.action == bact_pkg::ACT_ALIGNED) begin
                    unique case (r_phase)
                        PH_ONE_BYTE: begin
                            priority if (i_sts.pad_gt1) begin
                                o_cmd.op_ld  = 1'b1;
                                o_cmd.op_sel = bact_pkg::OP_PAD;
                                n_phase      = PH_PADDING;
                                n_state      = S_BUMP;
                            end else if (i_sts.size_gt1) begin
                                o_cmd.op_ld  = 1'b1;
                                o_cmd.op_sel = bact_pkg::OP_SIZE_M1;
                                n_phase      = PH_BODY;
                                n_state      = S_BUMP;
                            end else begin
                                n_state = S_FINISH;
                            end
                        end
                        PH_PADDING: begin
                            if (i_sts.size_gt1) begin
                                o_cmd.op_ld  = 1'b1;
                                o_cmd.op_sel = bact_pkg::OP_SIZE_M1;
                                n_phase      = PH_BODY;
                                n_state      = S_BUMP;
                            end
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_in_ready   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_ONE_BYTE;
            r_fin      <= bact_pkg::ST_OK;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_fin      <= n_fin;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

`default_nettype wire

/* rtl/bump_arena_commit_tracker.sv */
// Each watermark growth adds a pass through the 32-step remainder unit, and an
// aligned push runs up to three sub-pushes. Throughput: one item at a time; the
// next item is taken once the result is in the output register, while that result
// still waits to be taken.
// Reset (synchronous, active low) clears both offsets and loads the default window
// and commit granularity.
`timescale 1ns / 1ps
`default_nettype none

module bump_arena_commit_tracker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    bact_in_if.sink                             i_in,
    bact_out_if.source                          o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [bact_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bact_pkg::OFF_W-1:0]     i_cfg_data
);

    // The controller owns the sequence of one item: decode, up to three
    // sub-pushes, and for each push or reserve that raises the watermark, a
    // remainder pass over the commit granularity. The datapath holds all
    // arithmetic and arena state and reports comparison flags back.

    bact_pkg::t_cmd w_cmd;
    bact_pkg::t_sts w_sts;
    logic           w_in_ready;

    bact_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready)
    );

    // The result register in the datapath decouples the output side, so a new
    // item is taken while the previous result is still held.
    bact_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in.valid),
        .i_in_data   (i_in.data),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_data  (o_out.data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

    assign i_in.ready = w_in_ready;

`ifndef SYNTHESIS
    // Only one item is in flight: an accept always closes the input side.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while an item is in flight");

    // The watermark moves only once the remainder pass has finished.
    a_grow_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.grow_commit |-> $past(w_sts.div_done))
        else $error("watermark grown without a finished remainder");

    // A failed item never reports a granted block.
    a_fail_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.status == bact_pkg::ST_OK) ||
                        (o_out.data.block_offset == '0))
        else $error("block offset reported on a failed item");

    // A new result is only written when the output register can take it.
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> w_sts.out_free)
        else $error("result overwritten before it was taken");
`endif

endmodule

`default_nettype wire

/* tb/sv/bact_arena_checker.sv */
// Result checker for the bump arena commit tracker: tracks the arena state from
// accepted items and configuration writes and compares every result item.
// Depends on bact_pkg and the channel interfaces in bact_ifs.
`timescale 1ns / 1ps

module bact_arena_checker
    import bact_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    bact_in_if                        i_in_ch,
    bact_out_if                       i_out_ch,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [OFF_W-1:0]     i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    // Shadow copy of the window, the step size and both offsets.
    logic [31:0] window;
    logic [31:0] granule;
    logic [31:0] alloc_off;
    logic [31:0] commit_mark;
    t_out_item   arena_reports [$];
    int          mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Raise the watermark in whole steps to cover the target, never past the window.
    function automatic void raise_watermark(input logic [63:0] target);
        logic [63:0] step_sz;
        logic [63:0] steps;
        logic [63:0] next_mark;
        step_sz   = (granule == 0) ? 64'd1 : {32'd0, granule};
        steps     = (target - {32'd0, commit_mark} + step_sz - 1) / step_sz;
        next_mark = {32'd0, commit_mark} + steps * step_sz;
        if (next_mark > {32'd0, window}) next_mark = {32'd0, window};
        if (next_mark > {32'd0, commit_mark}) commit_mark = next_mark[31:0];
    endfunction

    function automatic t_status bump_offset(input logic [63:0] amount,
                                            output logic [63:0] start);
        logic [63:0] rounded;
        logic [63:0] stop;
        start = 64'd0;
        if (amount == 0) return ST_BAD_SIZE;
        rounded = (amount + 7) & ~64'd7;
        stop    = {32'd0, alloc_off} + rounded;
        if (stop > {32'd0, window}) return ST_NO_MEM;
        if (stop > {32'd0, commit_mark}) raise_watermark(stop);
        start     = {32'd0, alloc_off};
        alloc_off = stop[31:0];
        return ST_OK;
    endfunction

    // Up to three plain pushes in a row; whatever succeeded before a failure stays.
    function automatic t_status aligned_push(input logic [63:0] amount,
                                             input logic [63:0] align,
                                             output logic [63:0] start);
        logic [63:0] cur;
        logic [63:0] snapped;
        logic [63:0] pad;
        logic [63:0] scratch;
        t_status     st;
        start = 64'd0;
        if (align == 0 || (align & (align - 1)) != 0) return ST_BAD_PARAM;
        st = bump_offset(64'd1, cur);
        if (st != ST_OK) return st;
        snapped = (cur + align - 1) & ~(align - 1);
        pad     = snapped - cur;
        if (pad > 1) begin
            st = bump_offset(pad - 1, scratch);
            if (st != ST_OK) return st;
        end
        if (amount > 1) begin
            st = bump_offset(amount - 1, scratch);
            if (st != ST_OK) return st;
        end
        start = snapped;
        return ST_OK;
    endfunction

    function automatic t_status reserve_upto(input logic [63:0] target);
        if (target > {32'd0, window}) return ST_BAD_PARAM;
        if ({32'd0, commit_mark} >= target) return ST_OK;
        raise_watermark(target);
        return ST_OK;
    endfunction

    function automatic t_out_item arena_apply(input t_in_item it);
        t_out_item   rep;
        t_status     st;
        logic [63:0] start;
        logic [63:0] target;
        start = 64'd0;
        case (it.action)
            ACT_PUSH:    st = bump_offset({32'd0, it.size}, start);
            ACT_ALIGNED: st = aligned_push({32'd0, it.size}, {32'd0, it.alignment}, start);
            ACT_RESERVE: st = reserve_upto({32'd0, it.capacity_target});
            ACT_GROWTH: begin
                target = {32'd0, it.size} << 1;
                if (target < {32'd0, it.expected_total / 4})
                    target = {32'd0, it.expected_total / 4};
                st = reserve_upto(target);
            end
            ACT_RESET: begin
                alloc_off = '0;
                st        = ST_OK;
            end
            ACT_QUERY:   st = ST_OK;
            default:     st = ST_BAD_PARAM;
        endcase
        if (st != ST_OK) start = 64'd0;
        rep.status        = st;
        rep.block_offset  = start[31:0];
        rep.allocated_now = alloc_off;
        rep.committed_now = commit_mark;
        rep.headroom      = (alloc_off > window) ? '0 : window - alloc_off;
        rep.fits          = ({32'd0, alloc_off} + {32'd0, it.size} <= {32'd0, window});
        return rep;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%08h, actual 0x%08h", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            window      = RESERVED_RST;
            granule     = GRAN_RST;
            alloc_off   = '0;
            commit_mark = '0;
            arena_reports.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_RESERVED_SIZE) window = i_cfg_data;
                else if (i_cfg_idx == CFG_COMMIT_GRAN) granule = i_cfg_data;
            end
            // Results are retired before new items are queued in the same cycle.
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (arena_reports.size() == 0) begin
                    $error("Result item arrived with no accepted item waiting for it");
                    mismatches++;
                end else begin
                    want = arena_reports.pop_front();
                    check_field("status", want.status, i_out_ch.data.status);
                    check_field("block_offset", want.block_offset,
                                i_out_ch.data.block_offset);
                    check_field("allocated_now", want.allocated_now,
                                i_out_ch.data.allocated_now);
                    check_field("committed_now", want.committed_now,
                                i_out_ch.data.committed_now);
                    check_field("headroom", want.headroom, i_out_ch.data.headroom);
                    check_field("fits", want.fits, i_out_ch.data.fits);
                end
            end
            if (i_in_ch.valid && i_in_ch.ready)
                arena_reports.push_back(arena_apply(i_in_ch.data));
        end
        o_pending    <= arena_reports.size();
        o_fail_count <= mismatches;
    end

endmodule

/* tb/sv/bump_arena_commit_tracker_tb.sv */
// Top of the bump arena commit tracker testbench: clock, reset, item stimulus,
// configuration phases and the final verdict.
// Depends on bact_pkg, bact_ifs, bact_arena_checker and the block itself.
`timescale 1ns / 1ps

module bump_arena_commit_tracker_tb;
    import bact_pkg::*;

    // Action codes the block does not use; both must be answered as bad parameters.
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS = 2000;
    localparam int NUM_PHASES   = 7;
    localparam int IDLE_PCT     = 20;
    // The phase with the full-size window runs with no idling on either channel.
    localparam int STEADY_PHASE = 5;
    // An aligned push can run up to three watermark growths.
    localparam int TAIL_CYCLES  = 150;

    // Windows mostly grow from phase to phase because the watermark never drops: a
    // small window after a large one would leave nothing for the pushes to commit.
    // The zero window comes after allocations, so it also shrinks the window below
    // the allocated offset. Step sizes cover zero, one, an odd value and the maximum.
    localparam logic [31:0] PHASE_WINDOW [NUM_PHASES] = '{
        32'h0002_0000, 32'h0004_0000, 32'h0010_0000, 32'h0100_0000,
        32'h0000_0000, 32'hFFFF_FFFF, 32'h1000_0000
    };
    localparam logic [31:0] PHASE_GRAN [NUM_PHASES] = '{
        32'd64, 32'd0, 32'd3, 32'hFFFF_FFFF,
        32'd4096, 32'd1, 32'd4096
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [OFF_W-1:0]     cfg_data;
    logic                 steady;
    int                   items_sent;
    int                   fail_count;
    int                   pending;

    bact_in_if  in_ch ();
    bact_out_if out_ch ();

    bump_arena_commit_tracker DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    bact_arena_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The result side stalls at random, about one time in five, except in the steady phase.
    always @(negedge i_clk) begin
        out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic t_in_item arena_cmd(input logic [2:0] act, input logic [31:0] sz,
                                           input logic [31:0] al, input logic [31:0] cap,
                                           input logic [31:0] tot);
        t_in_item it;
        it.action          = act;
        it.size            = sz;
        it.alignment       = al;
        it.capacity_target = cap;
        it.expected_total  = tot;
        return it;
    endfunction

    // Sizes are mostly small, so that a window fills over many pushes; now and then
    // they are a fair part of the window or any 32-bit value at all.
    function automatic logic [31:0] pick_amount(input logic [31:0] win);
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(200, 1);
        if (r < 85) return $urandom_range(4096, 0);
        if (r < 95) return $urandom_range(win >> 3, 0);
        return $urandom;
    endfunction

    // One random item for the given window. Fields an action ignores keep random
    // values, so that every bit of every field toggles.
    function automatic t_in_item make_item(input logic [31:0] win);
        t_in_item it;
        int       r;
        it = arena_cmd(ACT_QUERY, $urandom, $urandom, $urandom, $urandom);
        r  = $urandom_range(99);
        if (r < 32) begin
            it.action = ACT_PUSH;
            it.size   = pick_amount(win);
        end else if (r < 54) begin
            it.action = ACT_ALIGNED;
            it.size   = pick_amount(win);
            r = $urandom_range(99);
            // Most alignments are small powers of two; a few are huge ones and the
            // rest keep the random value, which is almost never a power of two.
            if (r < 85) it.alignment = 32'd1 << $urandom_range(12, 0);
            else if (r < 92) it.alignment = 32'd1 << $urandom_range(31, 13);
        end else if (r < 66) begin
            it.action = ACT_RESERVE;
            r = $urandom_range(99);
            if (r < 80) it.capacity_target = $urandom_range(win >> 6, 0);
            else if (r < 90) it.capacity_target = win + $urandom_range(2, 0) - 1;
        end else if (r < 78) begin
            it.action = ACT_GROWTH;
            it.size   = pick_amount(win);
            if ($urandom_range(1) == 1) it.expected_total = $urandom_range(win, 0);
        end else if (r < 82) begin
            it.action = ACT_RESET;
        end else if (r < 98) begin
            it.action = ACT_QUERY;
            it.size   = pick_amount(win);
        end else begin
            it.action = $urandom_range(ACT_SPARE_HI, ACT_SPARE_LO);
        end
        return it;
    endfunction

    // Offers one item and returns once it has been accepted. Idle cycles before the
    // item carry noise on the data lines, which the block must ignore.
    task automatic offer(input t_in_item it);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            in_ch.data  <= make_item(32'hFFFF_FFFF);
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Holds the input side off until every accepted item has its result.
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [OFF_W-1:0] value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        steady       = 1'b0;
        items_sent   = 0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items under the reset window (256 MiB) and 4 KiB steps. The
        // watermark is kept low here, since the phases after it need room to grow.
        offer(arena_cmd(ACT_QUERY, 32'd0, 32'd0, 32'd0, 32'd0));
        // A zero-size push is rejected and changes nothing.
        offer(arena_cmd(ACT_PUSH, 32'd0, 32'd0, 32'd0, 32'd0));
        offer(arena_cmd(ACT_PUSH, 32'd1, 32'd0, 32'd0, 32'd0));
        offer(arena_cmd(ACT_PUSH, 32'd7, 32'd0, 32'd0, 32'd0));
        // A push far past the end of the window runs out of memory.
        offer(arena_cmd(ACT_PUSH, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0));
        // A zero alignment and one that is not a power of two are both refused.
        offer(arena_cmd(ACT_ALIGNED, 32'd16, 32'd0, 32'd0, 32'd0));
        offer(arena_cmd(ACT_ALIGNED, 32'd16, 32'd24, 32'd0, 32'd0));
        offer(arena_cmd(ACT_ALIGNED, 32'd100, 32'd64, 32'd0, 32'd0));
        offer(arena_cmd(ACT_ALIGNED, 32'd0, 32'd1, 32'd0, 32'd0));
        // The padding sub-push fails here, while the one-byte sub-push before it stays.
        offer(arena_cmd(ACT_ALIGNED, 32'd1, 32'h8000_0000, 32'd0, 32'd0));
        offer(arena_cmd(ACT_RESERVE, 32'd0, 32'd0, 32'h0001_0000, 32'd0));
        // A target already below the watermark succeeds with no change.
        offer(arena_cmd(ACT_RESERVE, 32'd0, 32'd0, 32'h0000_0100, 32'd0));
        // A target above the window is a bad parameter.
        offer(arena_cmd(ACT_RESERVE, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0));
        // Growth takes twice the size, or a quarter of the total when that is larger.
        offer(arena_cmd(ACT_GROWTH, 32'h0000_1000, 32'd0, 32'd0, 32'd0));
        offer(arena_cmd(ACT_GROWTH, 32'h0000_1000, 32'd0, 32'd0, 32'h0004_8000));
        // Twice the largest size needs a 33rd bit and lands above the window.
        offer(arena_cmd(ACT_GROWTH, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF));
        offer(arena_cmd(ACT_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF));
        offer(arena_cmd(ACT_SPARE_LO, 32'd8, 32'd8, 32'd8, 32'd8));
        offer(arena_cmd(ACT_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF));
        offer(arena_cmd(ACT_RESET, 32'd0, 32'd0, 32'd0, 32'd0));
        offer(arena_cmd(ACT_PUSH, 32'd24, 32'd0, 32'd0, 32'd0));
        settle();

        // Random phases, each under its own window and step size. Every phase
        // boundary waits for all results, so the registers only change while idle.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(CFG_RESERVED_SIZE, PHASE_WINDOW[p]);
            write_reg(CFG_COMMIT_GRAN, PHASE_GRAN[p]);
            steady <= (p == STEADY_PHASE);
            repeat (RANDOM_ITEMS / NUM_PHASES) offer(make_item(PHASE_WINDOW[p]));
            settle();
        end
        steady <= 1'b0;

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Run covered %0d items under the reset window and %0d further settings,",
                 items_sent, NUM_PHASES);
        $display("with random stalls on both channels and one phase at full rate.");
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Guard against a hang: the slowest correct run is well under a millisecond.
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
